// ===== rtl/core/udp_socket_table_demux_macros.svh =====
// ----------------------------------------------------------------------------
// udp socket table demux assertion macros
// Concurrent assertion wrappers used by the block's top RTL file.
// ----------------------------------------------------------------------------
`ifndef UDP_SOCKET_TABLE_DEMUX_MACROS_SVH
`define UDP_SOCKET_TABLE_DEMUX_MACROS_SVH

`ifndef ASSERT_OFF
// property checked while reset is released
`define USD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked at every edge, reset included
`define USD_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define USD_ASSERT(label, clk, rst_n, prop, msg)
`define USD_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

// ===== rtl/core/usd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usd_pkg
// Shared types and constants of the udp socket table demux.
// ----------------------------------------------------------------------------
package usd_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int IDX_W_DEF = $clog2(SLOTS_DEF);
    localparam int HDR_BYTES = 8;

    // operation codes
    typedef enum logic [2:0] {
        FN_CREATE  = 3'd0,
        FN_BIND    = 3'd1,
        FN_CONNECT = 3'd2,
        FN_SET_RCV = 3'd3,
        FN_REMOVE  = 3'd4,
        FN_SEND    = 3'd5,
        FN_LOOKUP  = 3'd6,
        FN_NOP     = 3'd7
    } t_func;

    // result status codes
    typedef enum logic [3:0] {
        ST_DONE      = 4'd0,
        ST_FULL      = 4'd1,
        ST_UNUSED    = 4'd2,
        ST_IN_USE    = 4'd3,
        ST_DELIVERED = 4'd4,
        ST_SHORT     = 4'd5,
        ST_NO_MATCH  = 4'd6,
        ST_NO_RCV    = 4'd7,
        ST_NO_DEST   = 4'd8,
        ST_TOO_LONG  = 4'd9
    } t_status;

    // fixed-width part of one table entry (age rank is appended below it)
    typedef struct packed {
        logic [31:0] bind_ip;
        logic [15:0] bind_port;
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        logic        receiver;
    } t_ent_fix;

    localparam int FIX_W = $bits(t_ent_fix);

    // fields of the current beat used while walking the table
    typedef struct packed {
        logic [31:0] lip;
        logic [15:0] lport;
        logic [31:0] sip;
        logic [15:0] sport;
        logic [15:0] dport;
    } t_query;

    // per-entry context from the sequencer
    typedef struct packed {
        logic vld;
        logic bound;
        logic tgt;
        logic have_best;
    } t_ctx;

    // per-entry verdict back to the sequencer
    typedef struct packed {
        logic hit;
        logic clash;
        logic wr;
    } t_cmp;

endpackage

// ===== rtl/core/usd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usd_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module usd_ram #(
    parameter int WIDTH = usd_pkg::FIX_W + usd_pkg::IDX_W_DEF,
    parameter int DEPTH = usd_pkg::SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/usd_entry_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usd_entry_cmp
// Evaluates one table entry read during a walk: lookup hit, bind clash
// and age rank update for create and remove.
// ----------------------------------------------------------------------------
module usd_entry_cmp #(
    parameter int IW = usd_pkg::IDX_W_DEF
) (
    input  usd_pkg::t_func    i_func,
    input  usd_pkg::t_query   i_query,
    input  usd_pkg::t_ent_fix i_ent,
    input  logic [IW-1:0]     i_rank,
    input  logic [IW-1:0]     i_tgt_rank,
    input  logic [IW-1:0]     i_best_rank,
    input  usd_pkg::t_ctx     i_ctx,
    output usd_pkg::t_cmp     o_res,
    output logic [IW-1:0]     o_rank_nxt
);

    logic live_bound;
    logic port_ok;
    logic peer_ok;

    // demux filter: local port exact, peer fields wildcard when zero
    assign live_bound = i_ctx.vld && i_ctx.bound;
    assign port_ok    = (i_ent.bind_port == i_query.dport);
    assign peer_ok    = ((i_ent.peer_port == '0) || (i_ent.peer_port == i_query.sport)) &&
                        ((i_ent.peer_ip == '0) || (i_ent.peer_ip == i_query.sip));

    always_comb begin
        o_res      = '0;
        o_rank_nxt = i_rank;
        case (i_func)
            usd_pkg::FN_LOOKUP: begin
                // newest entry wins: lower rank is younger
                o_res.hit = live_bound && port_ok && peer_ok &&
                            (!i_ctx.have_best || (i_rank < i_best_rank));
            end
            usd_pkg::FN_BIND: begin
                o_res.clash = live_bound && !i_ctx.tgt &&
                              (i_ent.bind_port == i_query.lport) &&
                              (i_ent.bind_ip == i_query.lip);
            end
            usd_pkg::FN_CREATE: begin
                // every live entry ages by one
                o_res.wr   = i_ctx.vld;
                o_rank_nxt = i_rank + 1'b1;
            end
            usd_pkg::FN_REMOVE: begin
                // entries older than the removed one move up
                o_res.wr   = i_ctx.vld && !i_ctx.tgt && (i_rank > i_tgt_rank);
                o_rank_nxt = i_rank - 1'b1;
            end
            default: begin
                o_res      = '0;
                o_rank_nxt = i_rank;
            end
        endcase
    end

endmodule

// ===== rtl/core/udp_socket_table_demux.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_socket_table_demux
// Accept to result strobe: no-op and early refusals go straight to S_FIN;
// connect, set receiver and send pass S_TGT; create and lookup walk the table
// in S_WALK; bind and remove pass S_TGT, then S_WALK. The strobe is registered
// from S_FIN; one beat in flight, next start taken in the strobe cycle. Walks
// read one entry a cycle through the entry RAM read port. Sync reset clears
// control, valid and bound flags; create writes RAM words before use. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`include "udp_socket_table_demux_macros.svh"

module udp_socket_table_demux #(
    parameter int SLOTS = usd_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_func,
    input  logic [2:0]  i_slot,
    input  logic [31:0] i_bind_ip,
    input  logic [15:0] i_bind_port,
    input  logic [31:0] i_peer_ip,
    input  logic [15:0] i_peer_port,
    input  logic        i_has_receiver,
    input  logic [15:0] i_payload_len,
    input  logic [31:0] i_src_ip,
    input  logic [15:0] i_seg_sport,
    input  logic [15:0] i_seg_dport,
    input  logic [15:0] i_seg_len,
    output logic        o_res_valid,
    output logic [3:0]  o_status,
    output logic [2:0]  o_result_slot,
    output logic [31:0] o_send_dst_ip,
    output logic [15:0] o_send_sport,
    output logic [15:0] o_send_dport,
    output logic [15:0] o_send_length
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = IW + 1;
    localparam int FW = usd_pkg::FIX_W;
    localparam int EW = FW + IW;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_TGT  = 4'b0010,
        S_WALK = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [SLOTS-1:0] r_valid;
    logic [SLOTS-1:0] r_bound;

    // latched beat
    usd_pkg::t_func  r_func;
    usd_pkg::t_query r_q;
    logic [IW-1:0]   r_idx;
    logic            r_live;
    logic            r_full;
    logic            r_short;
    logic [IW-1:0]   r_pick;
    logic [31:0]     r_rip;
    logic [15:0]     r_rport;
    logic            r_rcv;
    logic [15:0]     r_plen;

    // target entry
    usd_pkg::t_ent_fix r_tgt;
    logic [IW-1:0]     r_tgt_rank;

    // walk pipeline and accumulators
    logic [CW-1:0] r_rd_cnt;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    logic          r_have_best;
    logic [IW-1:0] r_best_rank;
    logic [IW-1:0] r_best_idx;
    logic          r_best_rcv;
    logic          r_clash;

    // result registers
    logic             r_res_vld;
    usd_pkg::t_status r_status, n_status;
    logic [2:0]       r_rslot, n_rslot;
    logic [31:0]      r_dip, n_dip;
    logic [15:0]      r_sport, n_sport;
    logic [15:0]      r_dport, n_dport;
    logic [15:0]      r_len, n_len;

    logic          acc;
    logic [IW-1:0] in_idx;
    logic          in_live;
    logic          free_any;
    logic [IW-1:0] free_idx;
    logic          in_short;
    usd_pkg::t_func in_func;
    logic          walk_last;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    usd_pkg::t_ent_fix rd_fix;
    logic [IW-1:0]     rd_rank;
    usd_pkg::t_ctx     cmp_ctx;
    usd_pkg::t_cmp     cmp_res;
    logic [IW-1:0]     cmp_rank;
    usd_pkg::t_ent_fix wfix;
    logic [IW-1:0]     wrank;

    logic [31:0] snd_dip;
    logic [15:0] snd_dport;
    logic [16:0] snd_total;

    logic fin_now;
    logic rm_walk_wr;
    logic create_fin;

    // input handshake
    assign busy    = (r_state != S_IDLE);
    assign acc     = start && !busy;
    assign in_func = usd_pkg::t_func'(i_func);
    assign in_idx  = IW'(i_slot);
    assign in_live = (32'(i_slot) < SLOTS) && r_valid[in_idx];
    assign in_short = (i_seg_len < 16'(usd_pkg::HDR_BYTES));

    // lowest free slot
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    // entry word split
    assign rd_fix  = usd_pkg::t_ent_fix'(ram_rdata[EW-1:IW]);
    assign rd_rank = ram_rdata[IW-1:0];

    assign walk_last = r_rd_vld && (r_rd_idx == IW'(SLOTS - 1));

    // entry evaluation during the walk
    assign cmp_ctx.vld       = r_valid[r_rd_idx];
    assign cmp_ctx.bound     = r_bound[r_rd_idx];
    assign cmp_ctx.tgt       = (r_rd_idx == r_idx);
    assign cmp_ctx.have_best = r_have_best;

    usd_entry_cmp #(
        .IW (IW)
    ) u_cmp (
        .i_func      (r_func),
        .i_query     (r_q),
        .i_ent       (rd_fix),
        .i_rank      (rd_rank),
        .i_tgt_rank  (r_tgt_rank),
        .i_best_rank (r_best_rank),
        .i_ctx       (cmp_ctx),
        .o_res       (cmp_res),
        .o_rank_nxt  (cmp_rank)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (in_func)
                        usd_pkg::FN_CREATE: n_state = free_any ? S_WALK : S_FIN;
                        usd_pkg::FN_LOOKUP: n_state = in_short ? S_FIN : S_WALK;
                        usd_pkg::FN_NOP:    n_state = S_FIN;
                        default:            n_state = in_live ? S_TGT : S_FIN;
                    endcase
                end
            end
            S_TGT: begin
                n_state = ((r_func == usd_pkg::FN_BIND) || (r_func == usd_pkg::FN_REMOVE))
                          ? S_WALK : S_FIN;
            end
            S_WALK: begin
                if (walk_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // RAM write data for the commit step
    always_comb begin
        wfix  = r_tgt;
        wrank = r_tgt_rank;
        case (r_func)
            usd_pkg::FN_CREATE: begin
                wfix  = '0;
                wrank = '0;
            end
            usd_pkg::FN_BIND: begin
                wfix.bind_ip   = r_q.lip;
                wfix.bind_port = r_q.lport;
            end
            usd_pkg::FN_CONNECT: begin
                wfix.peer_ip   = r_rip;
                wfix.peer_port = r_rport;
            end
            usd_pkg::FN_SET_RCV: wfix.receiver = r_rcv;
            default: begin
                wfix  = r_tgt;
                wrank = r_tgt_rank;
            end
        endcase
    end

    // RAM port control
    always_comb begin
        ram_raddr = (r_state == S_IDLE) ? in_idx : r_rd_cnt[IW-1:0];
        ram_we    = 1'b0;
        ram_waddr = r_rd_idx;
        ram_wdata = {rd_fix, cmp_rank};
        case (r_state)
            S_WALK: ram_we = r_rd_vld && cmp_res.wr;
            S_FIN: begin
                ram_wdata = {wfix, wrank};
                case (r_func)
                    usd_pkg::FN_CREATE: begin
                        ram_we    = !r_full;
                        ram_waddr = r_pick;
                    end
                    usd_pkg::FN_BIND: begin
                        ram_we    = r_live && !r_clash;
                        ram_waddr = r_idx;
                    end
                    usd_pkg::FN_CONNECT,
                    usd_pkg::FN_SET_RCV: begin
                        ram_we    = r_live;
                        ram_waddr = r_idx;
                    end
                    default: ram_we = 1'b0;
                endcase
            end
            default: ram_we = 1'b0;
        endcase
    end

    usd_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // send header resolution
    assign snd_dip   = (r_rip != '0) ? r_rip : r_tgt.peer_ip;
    assign snd_dport = (r_rport != '0) ? r_rport : r_tgt.peer_port;
    assign snd_total = {1'b0, r_plen} + 17'(usd_pkg::HDR_BYTES);

    // result of the finished beat
    always_comb begin
        n_status = usd_pkg::ST_DONE;
        n_rslot  = '0;
        n_dip    = '0;
        n_sport  = '0;
        n_dport  = '0;
        n_len    = '0;
        case (r_func)
            usd_pkg::FN_CREATE: begin
                if (r_full) begin
                    n_status = usd_pkg::ST_FULL;
                end else begin
                    n_rslot = 3'(r_pick);
                end
            end
            usd_pkg::FN_LOOKUP: begin
                if (r_short) begin
                    n_status = usd_pkg::ST_SHORT;
                end else if (!r_have_best) begin
                    n_status = usd_pkg::ST_NO_MATCH;
                end else begin
                    n_status = r_best_rcv ? usd_pkg::ST_DELIVERED : usd_pkg::ST_NO_RCV;
                    n_rslot  = 3'(r_best_idx);
                end
            end
            usd_pkg::FN_NOP: n_status = usd_pkg::ST_DONE;
            default: begin
                if (!r_live) begin
                    n_status = usd_pkg::ST_UNUSED;
                end else if (r_func == usd_pkg::FN_BIND) begin
                    n_status = r_clash ? usd_pkg::ST_IN_USE : usd_pkg::ST_DONE;
                end else if (r_func == usd_pkg::FN_SEND) begin
                    if ((snd_dip == '0) || (snd_dport == '0)) begin
                        n_status = usd_pkg::ST_NO_DEST;
                    end else if (snd_total[16]) begin
                        n_status = usd_pkg::ST_TOO_LONG;
                    end else begin
                        n_dip   = snd_dip;
                        n_sport = r_tgt.bind_port;
                        n_dport = snd_dport;
                        n_len   = snd_total[15:0];
                    end
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_bound     <= '0;
            r_rd_cnt    <= '0;
            r_rd_vld    <= 1'b0;
            r_have_best <= 1'b0;
            r_clash     <= 1'b0;
            r_res_vld   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_res_vld <= (r_state == S_FIN);

            // walk read issue, one entry a cycle
            if (r_state == S_WALK) begin
                if (r_rd_cnt < CW'(SLOTS)) begin
                    r_rd_cnt <= r_rd_cnt + 1'b1;
                    r_rd_vld <= 1'b1;
                end else begin
                    r_rd_vld <= 1'b0;
                end
            end else begin
                r_rd_cnt <= '0;
                r_rd_vld <= 1'b0;
            end

            // walk accumulators
            if ((r_state == S_IDLE) || (r_state == S_TGT)) begin
                r_have_best <= 1'b0;
                r_clash     <= 1'b0;
            end else if ((r_state == S_WALK) && r_rd_vld) begin
                if (cmp_res.hit) begin
                    r_have_best <= 1'b1;
                end
                if (cmp_res.clash) begin
                    r_clash <= 1'b1;
                end
            end

            // commit flags
            if (r_state == S_FIN) begin
                case (r_func)
                    usd_pkg::FN_CREATE: begin
                        if (!r_full) begin
                            r_valid[r_pick] <= 1'b1;
                            r_bound[r_pick] <= 1'b0;
                        end
                    end
                    usd_pkg::FN_BIND: begin
                        if (r_live && !r_clash) begin
                            r_bound[r_idx] <= 1'b1;
                        end
                    end
                    usd_pkg::FN_REMOVE: begin
                        if (r_live) begin
                            r_valid[r_idx] <= 1'b0;
                            r_bound[r_idx] <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_func    <= in_func;
            r_idx     <= in_idx;
            r_live    <= in_live;
            r_full    <= !free_any;
            r_pick    <= free_idx;
            r_short   <= in_short;
            r_q.lip   <= i_bind_ip;
            r_q.lport <= i_bind_port;
            r_q.sip   <= i_src_ip;
            r_q.sport <= i_seg_sport;
            r_q.dport <= i_seg_dport;
            r_rip     <= i_peer_ip;
            r_rport   <= i_peer_port;
            r_rcv     <= i_has_receiver;
            r_plen    <= i_payload_len;
        end
        if (r_state == S_TGT) begin
            r_tgt      <= rd_fix;
            r_tgt_rank <= rd_rank;
        end
        if (r_state == S_WALK) begin
            r_rd_idx <= r_rd_cnt[IW-1:0];
        end
        if ((r_state == S_WALK) && r_rd_vld && cmp_res.hit) begin
            r_best_rank <= rd_rank;
            r_best_idx  <= r_rd_idx;
            r_best_rcv  <= rd_fix.receiver;
        end
        if (r_state == S_FIN) begin
            r_status <= n_status;
            r_rslot  <= n_rslot;
            r_dip    <= n_dip;
            r_sport  <= n_sport;
            r_dport  <= n_dport;
            r_len    <= n_len;
        end
    end

    // result ports
    assign o_res_valid     = r_res_vld;
    assign o_status        = r_status;
    assign o_result_slot   = r_rslot;
    assign o_send_dst_ip   = r_dip;
    assign o_send_sport    = r_sport;
    assign o_send_dport    = r_dport;
    assign o_send_length   = r_len;

    // check terms
    assign fin_now    = (r_state == S_FIN);
    assign rm_walk_wr = (r_state == S_WALK) && ram_we && (r_func == usd_pkg::FN_REMOVE);
    assign create_fin = fin_now && (r_func == usd_pkg::FN_CREATE) && !r_full;

    // checks
    `USD_ASSERT_NR(a_rst_idle, i_clk, !i_rst_n |=> !busy && !o_res_valid, "reset did not idle")
    `USD_ASSERT(a_res_after_fin, i_clk, i_rst_n, o_res_valid |-> $past(fin_now), "stray strobe")
    `USD_ASSERT(a_no_wr_idle, i_clk, i_rst_n, !busy |-> !ram_we, "RAM write while idle")
    `USD_ASSERT(a_rm_keeps_tgt, i_clk, i_rst_n, rm_walk_wr |-> ram_waddr != r_idx, "remove hit target")
    `USD_ASSERT(a_create_marks, i_clk, i_rst_n, create_fin |=> r_valid[$past(r_pick)], "slot unmarked")

endmodule

// ===== sim/udp_socket_table_demux_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_socket_table_demux_checker
// Watches the command and reply ports of the socket table demux. Each accepted
// beat is run through a cycle-free model of the endpoint table, and each reply
// strobe is compared field by field against the oldest reply still owed.
// ----------------------------------------------------------------------------
module udp_socket_table_demux_checker import usd_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  i_func,
    input  logic [2:0]  i_slot,
    input  logic [31:0] i_bind_ip,
    input  logic [15:0] i_bind_port,
    input  logic [31:0] i_peer_ip,
    input  logic [15:0] i_peer_port,
    input  logic        i_has_receiver,
    input  logic [15:0] i_payload_len,
    input  logic [31:0] i_src_ip,
    input  logic [15:0] i_seg_sport,
    input  logic [15:0] i_seg_dport,
    input  logic [15:0] i_seg_len,
    input  logic        o_res_valid,
    input  logic [3:0]  o_status,
    input  logic [2:0]  o_result_slot,
    input  logic [31:0] o_send_dst_ip,
    input  logic [15:0] o_send_sport,
    input  logic [15:0] o_send_dport,
    input  logic [15:0] o_send_length,
    output int          o_fail_count,
    output int          o_replies_left,
    output int          o_replies_seen,
    output int          o_deliveries,
    output int          o_sends
);

    typedef struct packed {
        t_status     status;
        logic [2:0]  slot;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] length;
    } t_reply;

    // shadow copy of the endpoint table
    logic        ent_valid [SLOTS];
    logic        ent_bound [SLOTS];
    logic [31:0] ent_lip   [SLOTS];
    logic [15:0] ent_lport [SLOTS];
    logic [31:0] ent_pip   [SLOTS];
    logic [15:0] ent_pport [SLOTS];
    logic        ent_rcv   [SLOTS];
    int unsigned ent_rank  [SLOTS];

    t_reply replies_due [$];

    // apply one command beat to the shadow table and work out its reply
    task automatic serve_socket_op(output t_reply r);
        int unsigned s;
        int unsigned k;
        int unsigned best;
        logic [31:0] dip;
        logic [15:0] dpt;
        logic [16:0] total;
        r = '0;
        r.status = ST_DONE;
        s = i_slot;
        case (t_func'(i_func))
            FN_CREATE: begin
                best = SLOTS;
                for (k = 0; k < SLOTS; k++)
                    if (!ent_valid[k] && best == SLOTS) best = k;
                if (best == SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    for (k = 0; k < SLOTS; k++)
                        if (ent_valid[k]) ent_rank[k]++;
                    ent_valid[best] = 1'b1;
                    ent_bound[best] = 1'b0;
                    ent_lip[best]   = '0;
                    ent_lport[best] = '0;
                    ent_pip[best]   = '0;
                    ent_pport[best] = '0;
                    ent_rcv[best]   = 1'b0;
                    ent_rank[best]  = 0;
                    r.slot = 3'(best);
                end
            end
            FN_LOOKUP: begin
                best = SLOTS;
                if (i_seg_len < HDR_BYTES) begin
                    r.status = ST_SHORT;
                end else begin
                    // newest bound entry whose port matches and whose peer fits
                    for (k = 0; k < SLOTS; k++) begin
                        if (ent_valid[k] && ent_bound[k] && ent_lport[k] == i_seg_dport &&
                            (ent_pport[k] == 0 || ent_pport[k] == i_seg_sport) &&
                            (ent_pip[k] == 0 || ent_pip[k] == i_src_ip) &&
                            (best == SLOTS || ent_rank[k] < ent_rank[best]))
                            best = k;
                    end
                    if (best == SLOTS) begin
                        r.status = ST_NO_MATCH;
                    end else begin
                        r.status = ent_rcv[best] ? ST_DELIVERED : ST_NO_RCV;
                        r.slot = 3'(best);
                    end
                end
            end
            FN_NOP: ;
            default: begin
                if (s >= SLOTS || !ent_valid[s]) begin
                    r.status = ST_UNUSED;
                end else begin
                    case (t_func'(i_func))
                        FN_BIND: begin
                            for (k = 0; k < SLOTS; k++)
                                if (k != s && ent_valid[k] && ent_bound[k] &&
                                    ent_lport[k] == i_bind_port && ent_lip[k] == i_bind_ip)
                                    r.status = ST_IN_USE;
                            if (r.status == ST_DONE) begin
                                ent_lip[s]   = i_bind_ip;
                                ent_lport[s] = i_bind_port;
                                ent_bound[s] = 1'b1;
                            end
                        end
                        FN_CONNECT: begin
                            ent_pip[s]   = i_peer_ip;
                            ent_pport[s] = i_peer_port;
                        end
                        FN_SET_RCV: ent_rcv[s] = i_has_receiver;
                        FN_REMOVE: begin
                            // close the age gap left by the removed entry
                            for (k = 0; k < SLOTS; k++)
                                if (k != s && ent_valid[k] && ent_rank[k] > ent_rank[s])
                                    ent_rank[k]--;
                            ent_valid[s] = 1'b0;
                            ent_bound[s] = 1'b0;
                        end
                        default: begin
                            // send: fall back to the connected peer
                            dip = (i_peer_ip != 0) ? i_peer_ip : ent_pip[s];
                            dpt = (i_peer_port != 0) ? i_peer_port : ent_pport[s];
                            total = {1'b0, i_payload_len} + 17'(HDR_BYTES);
                            if (dip == 0 || dpt == 0) begin
                                r.status = ST_NO_DEST;
                            end else if (total > 17'h0FFFF) begin
                                r.status = ST_TOO_LONG;
                            end else begin
                                r.dst_ip = dip;
                                r.sport  = ent_lport[s];
                                r.dport  = dpt;
                                r.length = total[15:0];
                            end
                        end
                    endcase
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            o_fail_count++;
        end
    endtask

    // compare the reply strobe first, then take the new beat
    always @(posedge i_clk) begin
        t_reply want;
        t_reply fresh;
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                ent_valid[k] = 1'b0;
                ent_bound[k] = 1'b0;
                ent_rank[k]  = 0;
            end
            replies_due.delete();
            o_fail_count   = 0;
            o_replies_left = 0;
            o_replies_seen = 0;
            o_deliveries   = 0;
            o_sends        = 0;
        end else begin
            if (o_res_valid) begin
                if (replies_due.size() == 0) begin
                    $error("reply strobe with nothing outstanding, status %0d", o_status);
                    o_fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("status", want.status, o_status);
                    check_field("result_slot", want.slot, o_result_slot);
                    check_field("send_dst_ip", want.dst_ip, o_send_dst_ip);
                    check_field("send_sport", want.sport, o_send_sport);
                    check_field("send_dport", want.dport, o_send_dport);
                    check_field("send_length", want.length, o_send_length);
                    o_replies_seen++;
                    if (want.status == ST_DELIVERED) o_deliveries++;
                    if (want.length != 0) o_sends++;
                end
            end
            if (start && !busy) begin
                serve_socket_op(fresh);
                replies_due.push_back(fresh);
            end
            o_replies_left = replies_due.size();
        end
    end

endmodule

// ===== sim/udp_socket_table_demux_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_socket_table_demux_test
// Drives the socket table demux with a directed set of corner commands and
// then with random command streams drawn from small address and port pools,
// so binds collide and lookups hit; replies are checked by the checker.
// ----------------------------------------------------------------------------
module udp_socket_table_demux_test;
    import usd_pkg::*;

    localparam int SLOTS       = SLOTS_DEF;
    localparam int RANDOM_OPS  = 400;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        t_func       func;
        logic [2:0]  slot;
        logic [31:0] bind_ip;
        logic [15:0] bind_port;
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        logic        has_receiver;
        logic [15:0] payload_len;
        logic [31:0] src_ip;
        logic [15:0] seg_sport;
        logic [15:0] seg_dport;
        logic [15:0] seg_len;
    } t_sock_op;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_func = '0;
    logic [2:0]  i_slot = '0;
    logic [31:0] i_bind_ip = '0;
    logic [15:0] i_bind_port = '0;
    logic [31:0] i_peer_ip = '0;
    logic [15:0] i_peer_port = '0;
    logic        i_has_receiver = 1'b0;
    logic [15:0] i_payload_len = '0;
    logic [31:0] i_src_ip = '0;
    logic [15:0] i_seg_sport = '0;
    logic [15:0] i_seg_dport = '0;
    logic [15:0] i_seg_len = '0;
    logic        o_res_valid;
    logic [3:0]  o_status;
    logic [2:0]  o_result_slot;
    logic [31:0] o_send_dst_ip;
    logic [15:0] o_send_sport;
    logic [15:0] o_send_dport;
    logic [15:0] o_send_length;

    int fail_count;
    int replies_left;
    int replies_seen;
    int deliveries;
    int sends;
    int cycle_count = 0;
    int burst_left = 0;

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    udp_socket_table_demux #(.SLOTS(SLOTS)) uut (.*);

    udp_socket_table_demux_checker #(.SLOTS(SLOTS)) watch (
        .*,
        .o_fail_count   (fail_count),
        .o_replies_left (replies_left),
        .o_replies_seen (replies_seen),
        .o_deliveries   (deliveries),
        .o_sends        (sends)
    );

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_sock_op blank_op(input t_func f, input logic [2:0] s);
        t_sock_op r;
        r = '0;
        r.func = f;
        r.slot = s;
        return r;
    endfunction

    // mostly a small pool so that binds clash and lookups hit
    function automatic logic [31:0] pick_ip();
        logic [31:0] r;
        case ($urandom_range(7))
            0: r = 32'h0A00_0001;
            1: r = 32'hC0A8_0102;
            2: r = 32'hFFFF_FFFF;
            3: r = 32'h0000_0001;
            4: r = 32'h0A00_0001;
            default: r = $urandom;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] pick_port();
        logic [15:0] r;
        case ($urandom_range(7))
            0: r = 16'd53;
            1: r = 16'd8080;
            2: r = 16'hFFFF;
            3: r = 16'd1;
            4: r = 16'd53;
            default: r = 16'($urandom);
        endcase
        return r;
    endfunction

    // random fields everywhere, shaped where the operation reads them
    function automatic t_sock_op rand_op();
        t_sock_op r;
        logic [223:0] raw;
        int unsigned roll;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        r = raw[$bits(t_sock_op)-1:0];
        r.slot = 3'($urandom_range(SLOTS - 1));
        roll = $urandom_range(99);
        if (roll < 14) begin
            r.func = FN_CREATE;
        end else if (roll < 24) begin
            r.func = FN_REMOVE;
        end else if (roll < 42) begin
            r.func = FN_BIND;
            r.bind_ip = pick_ip();
            r.bind_port = pick_port();
        end else if (roll < 52) begin
            r.func = FN_CONNECT;
            r.peer_ip = ($urandom_range(9) < 4) ? 32'h0 : pick_ip();
            r.peer_port = ($urandom_range(9) < 4) ? 16'h0 : pick_port();
        end else if (roll < 62) begin
            r.func = FN_SET_RCV;
        end else if (roll < 74) begin
            r.func = FN_SEND;
            r.peer_ip = $urandom_range(1) ? 32'h0 : pick_ip();
            r.peer_port = $urandom_range(1) ? 16'h0 : pick_port();
            case ($urandom_range(9))
                0: r.payload_len = 16'hFFF7;
                1: r.payload_len = 16'hFFF8;
                2: r.payload_len = 16'($urandom);
                default: r.payload_len = 16'($urandom_range(1500));
            endcase
        end else if (roll < 98) begin
            r.func = FN_LOOKUP;
            r.src_ip = pick_ip();
            r.seg_sport = pick_port();
            r.seg_dport = pick_port();
            r.seg_len = ($urandom_range(9) == 0) ? 16'($urandom_range(7))
                                                 : 16'($urandom_range(65535, 8));
        end else begin
            r.func = FN_NOP;
        end
        return r;
    endfunction

    // present one beat and hold it until the block takes it
    task automatic push_op(input t_sock_op op);
        @(negedge i_clk);
        i_func = op.func;
        i_slot = op.slot;
        i_bind_ip = op.bind_ip;
        i_bind_port = op.bind_port;
        i_peer_ip = op.peer_ip;
        i_peer_port = op.peer_port;
        i_has_receiver = op.has_receiver;
        i_payload_len = op.payload_len;
        i_src_ip = op.src_ip;
        i_seg_sport = op.seg_sport;
        i_seg_dport = op.seg_dport;
        i_seg_len = op.seg_len;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle(input int n);
        @(negedge i_clk);
        start = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // bursts of back-to-back beats broken by random gaps
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            if ($urandom_range(3) != 0) idle($urandom_range(12, 1));
            burst_left = $urandom_range(20);
        end
    endtask

    initial begin
        t_sock_op op;
        int n;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        idle(3);

        // empty table: lookup finds nothing, short segments dropped first
        op = blank_op(FN_LOOKUP, 3'd0);
        op.seg_len = 16'd8;
        push_op(op);
        op.seg_len = 16'd7;
        push_op(op);
        // commands to slots never created
        op = blank_op(FN_BIND, 3'd0);
        push_op(op);
        op = blank_op(FN_SEND, 3'd7);
        push_op(op);
        // fill every slot, then one more create
        for (int k = 0; k <= SLOTS; k++) push_op(blank_op(FN_CREATE, 3'd0));
        // bind, clash from another slot, rebind with own pair
        op = blank_op(FN_BIND, 3'd0);
        op.bind_ip = '1;
        op.bind_port = '1;
        push_op(op);
        op.slot = 3'd1;
        push_op(op);
        op.slot = 3'd0;
        push_op(op);
        // send with no peer and no destination
        push_op(blank_op(FN_SEND, 3'd0));
        op = blank_op(FN_CONNECT, 3'd0);
        op.peer_ip = '1;
        op.peer_port = '1;
        push_op(op);
        // longest send that fits, then one byte over
        op = blank_op(FN_SEND, 3'd0);
        op.payload_len = 16'hFFF7;
        push_op(op);
        op.payload_len = 16'hFFF8;
        push_op(op);
        // match without receiver, then with one
        op = blank_op(FN_LOOKUP, 3'd0);
        op.src_ip = '1;
        op.seg_sport = '1;
        op.seg_dport = '1;
        op.seg_len = '1;
        push_op(op);
        op = blank_op(FN_SET_RCV, 3'd0);
        op.has_receiver = 1'b1;
        push_op(op);
        op = blank_op(FN_LOOKUP, 3'd0);
        op.src_ip = '1;
        op.seg_sport = '1;
        op.seg_dport = '1;
        op.seg_len = '1;
        push_op(op);
        push_op(blank_op(FN_REMOVE, 3'd0));
        push_op(blank_op(FN_NOP, 3'd0));
        idle($urandom_range(8, 1));

        // random command streams
        n = 0;
        while (n < RANDOM_OPS) begin
            op = rand_op();
            push_op(op);
            if (op.func != FN_NOP) n++;
            pace();
        end
        idle(1);

        // drain, then give a spurious strobe time to show up
        while (replies_left != 0) @(negedge i_clk);
        repeat (SLOTS + 8) @(negedge i_clk);

        $display("checked %0d replies over %0d cycles, directed corners plus random streams",
                 replies_seen, cycle_count);
        $display("lookups delivered: %0d, sends with a header: %0d", deliveries, sends);
        if (fail_count == 0 && replies_left == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
